>>> design/sgma_pkg.sv
package sgma_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 11;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned TDATA_W  = 16;

    // config port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_VALID_MAXIMUM = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_STEP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_AFTER  = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] VALID_MAXIMUM_RST = 11'd400;
    localparam logic [SAMPLE_W-1:0] ALLOWED_STEP_RST  = 11'd20;
    localparam logic [RUN_W-1:0]    ACCEPT_AFTER_RST  = 3'd3;

    localparam int unsigned WINDOW_LENGTH_DEFAULT = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage

>>> design/sgma_ram.sv
module sgma_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 5,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/sgma_div.sv
// Restoring divider, one quotient bit per cycle.
module sgma_div #(
    parameter int unsigned DIVIDEND_W = 14,
    parameter int unsigned DIVISOR_W  = 3,
    localparam int unsigned CNT_W     = $clog2(DIVIDEND_W + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/spike_gated_moving_average.sv
// Spike-gated moving average for one distance sensor. Each s_ transaction
// carries one 11-bit distance sample and yields exactly one m_ transaction.
// A sample of zero or above valid_maximum is ignored and the last stable
// value is returned. A sample further than allowed_step from the stable value
// is a jump: it is counted, and after accept_after jumps in a row it becomes
// the stable value; a jump is never averaged. Any other sample becomes the
// stable value, enters a circular window of WINDOW_LENGTH entries and the
// truncated mean of the samples held is returned. Timing: a held-off or jump
// sample passes from acceptance through the check state to the result
// register; an averaged sample also passes the update and divider states,
// waiting on the bit-serial divider that forms the mean one quotient bit per cycle.
// s_tready is high only while the block is idle; a finished result waits in
// the m_ output register and does not stop the next sample being taken.
// Configuration writes are taken at any edge with cfg_wr_en high and must
// only be issued while the block is idle.
module spike_gated_moving_average #(
    parameter int unsigned WINDOW_LENGTH = sgma_pkg::WINDOW_LENGTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [sgma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgma_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sgma_pkg::TDATA_W-1:0]        s_tdata,   // [10:0] sample
    // filtered output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sgma_pkg::TDATA_W-1:0]        m_tdata    // [10:0] filtered
);

    localparam int unsigned SW      = sgma_pkg::SAMPLE_W;
    localparam int unsigned RW      = sgma_pkg::RUN_W;
    // total of up to WINDOW_LENGTH samples
    localparam int unsigned TOTAL_W = SW + $clog2(WINDOW_LENGTH);
    localparam int unsigned CNT_W   = $clog2(WINDOW_LENGTH + 1);
    localparam int unsigned SLOT_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    // config registers
    logic [SW-1:0] vmax_reg;
    logic [SW-1:0] step_reg;
    logic [RW-1:0] accept_reg;

    sgma_pkg::state_t state_reg, state_next;

    logic [SW-1:0]      sample_reg, sample_next;
    logic [SW-1:0]      stable_reg, stable_next;
    logic [RW-1:0]      run_reg, run_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SW-1:0]      res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [SW-1:0]      m_data_reg, m_data_next;

    logic [SW-1:0]      diff;
    logic [RW-1:0]      run_inc;
    logic               ram_we;
    logic [SW-1:0]      ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_quo;

    // ---------------- config ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmax_reg   <= sgma_pkg::VALID_MAXIMUM_RST;
            step_reg   <= sgma_pkg::ALLOWED_STEP_RST;
            accept_reg <= sgma_pkg::ACCEPT_AFTER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sgma_pkg::REG_VALID_MAXIMUM: vmax_reg   <= cfg_wdata;
                sgma_pkg::REG_ALLOWED_STEP:  step_reg   <= cfg_wdata;
                sgma_pkg::REG_ACCEPT_AFTER:  accept_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- window store and divider ----------------
    // Read address is the write slot; the entry about to be replaced is read
    // in the check cycle and overwritten in the update cycle.
    sgma_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    sgma_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- state register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sgma_pkg::ST_IDLE;
            stable_reg  <= '0;
            run_reg     <= '0;
            total_reg   <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stable_reg  <= stable_next;
            run_reg     <= run_next;
            total_reg   <= total_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg <= sample_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        stable_next  = stable_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        // output register drains on a completed m_ transaction
        m_valid_next = m_valid_reg & ~m_tready;
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;

        diff    = (sample_reg >= stable_reg) ? (sample_reg - stable_reg)
                                             : (stable_reg - sample_reg);
        run_inc = run_reg + 1'b1;

        case (state_reg)
            sgma_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next = s_tdata[SW-1:0];
                    state_next  = sgma_pkg::ST_CHECK;
                end
            end
            sgma_pkg::ST_CHECK: begin
                if (sample_reg == '0 || sample_reg > vmax_reg) begin
                    // no echo or out of range: hold off, nothing changes
                    res_next   = stable_reg;
                    state_next = sgma_pkg::ST_FINISH;
                end else if (diff > step_reg) begin
                    // jump; accept_after of zero is always reached
                    if (run_inc >= accept_reg) begin
                        stable_next = sample_reg;
                        run_next    = '0;
                        res_next    = sample_reg;
                    end else begin
                        run_next    = run_inc;
                        res_next    = stable_reg;
                    end
                    state_next = sgma_pkg::ST_FINISH;
                end else begin
                    run_next    = '0;
                    stable_next = sample_reg;
                    state_next  = sgma_pkg::ST_UPDATE;
                end
            end
            sgma_pkg::ST_UPDATE: begin
                ram_we = 1'b1;
                if (fill_reg < CNT_W'(WINDOW_LENGTH)) begin
                    total_next = total_reg + TOTAL_W'(sample_reg);
                    fill_next  = fill_reg + 1'b1;
                end else begin
                    total_next = total_reg - TOTAL_W'(ram_rdata) + TOTAL_W'(sample_reg);
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW_LENGTH - 1)) ? '0
                                                                       : slot_reg + 1'b1;
                state_next = sgma_pkg::ST_DIV_START;
            end
            sgma_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = sgma_pkg::ST_DIV_WAIT;
            end
            sgma_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    // mean never exceeds the largest sample
                    res_next   = div_quo[SW-1:0];
                    state_next = sgma_pkg::ST_FINISH;
                end
            end
            sgma_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = sgma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sgma_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(sgma_pkg::TDATA_W - SW){1'b0}}, m_data_reg};

endmodule
